// ===== sv/rv32ex_pkg.sv =====
// Shared types and constants for the RV32IM execute unit.
// No dependencies; every other file in sv/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package rv32ex_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned SHAMT_W   = 5;
  localparam logic [31:0] LINK_OFFSET = 32'd4;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

  typedef enum logic [5:0] {
    OP_ADDI   = 6'd0,  OP_SLTI  = 6'd1,  OP_SLTIU = 6'd2,  OP_XORI  = 6'd3,
    OP_ORI    = 6'd4,  OP_ANDI  = 6'd5,  OP_LW    = 6'd6,  OP_SLLI  = 6'd7,
    OP_SRLI   = 6'd8,  OP_SRAI  = 6'd9,  OP_FENCE = 6'd10, OP_FENCEI = 6'd11,
    OP_ADD    = 6'd12, OP_SUB   = 6'd13, OP_SLL   = 6'd14, OP_SLT   = 6'd15,
    OP_SLTU   = 6'd16, OP_XOR   = 6'd17, OP_SRL   = 6'd18, OP_SRA   = 6'd19,
    OP_OR     = 6'd20, OP_AND   = 6'd21, OP_MUL   = 6'd22, OP_MULH  = 6'd23,
    OP_MULHSU = 6'd24, OP_MULHU = 6'd25, OP_DIV   = 6'd26, OP_DIVU  = 6'd27,
    OP_REM    = 6'd28, OP_REMU  = 6'd29, OP_JAL   = 6'd30, OP_BEQ   = 6'd31,
    OP_BNE    = 6'd32, OP_BLT   = 6'd33, OP_BGE   = 6'd34, OP_BLTU  = 6'd35,
    OP_BGEU   = 6'd36, OP_SW    = 6'd37
  } op_t;

  // Which unit supplies the final result.
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2,
    K_REM    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] result;
    logic        taken;
    logic [31:0] target;
    logic [31:0] sdata;
    logic        ill;
    logic        qneg;
    logic        rneg;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/rv32ex_top.sv =====
// Throughput: one transaction per cycle while the output register is not stalled;
// the 32-stage divider pipeline between decode and output registers sets the depth.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Top level of the execute unit; depends on rv32ex_pkg, rv32ex_decode,
// rv32ex_mul and rv32ex_div.
`timescale 1ns / 1ps
`default_nettype none
module rv32im_execute_unit_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // operation[5:0], rs1_value[37:6], rs2_value[69:38], imm_value[101:70],
  // pc_value[133:102], zero fill [135:134]
  input  wire logic [135:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // result[31:0], branch_target[63:32], store_data[95:64]
  output logic [95:0]        out_tdata,
  // branch_taken[0], illegal[1]
  output logic [1:0]         out_tuser
);

  localparam int unsigned N = rv32ex_pkg::DIV_STEPS;

  logic               en;
  logic               s1_vld;
  rv32ex_pkg::side_t  s1_side;
  logic [31:0]        div_a, div_b, quo, rem, mul_out;
  logic signed [32:0] mul_a, mul_b;
  logic               mul_hi;
  logic               vld_r [N];
  rv32ex_pkg::side_t  side_r [N];
  rv32ex_pkg::side_t  last;
  logic [31:0]        res_sel;
  logic               out_valid_r;
  logic [95:0]        out_data_r;
  logic [1:0]         out_user_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  rv32ex_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .operation (in_tdata[5:0]),
    .rs1_value (in_tdata[37:6]),
    .rs2_value (in_tdata[69:38]),
    .imm_value (in_tdata[101:70]),
    .pc_value  (in_tdata[133:102]),
    .vld_r     (s1_vld),
    .side_r    (s1_side),
    .div_a_r   (div_a),
    .div_b_r   (div_b),
    .mul_a_r   (mul_a),
    .mul_b_r   (mul_b),
    .mul_hi_r  (mul_hi)
  );

  rv32ex_mul u_mul (
    .clk     (clk),
    .en      (en),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_hi  (mul_hi),
    .mul_out (mul_out)
  );

  rv32ex_div u_div (
    .clk       (clk),
    .en        (en),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (quo),
    .remainder (rem)
  );

  // Sideband line that keeps each transaction's other outputs beside its divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= s1_vld;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s1_side;
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    last = side_r[N-1];
    case (last.kind)
      rv32ex_pkg::K_SIMPLE: res_sel = last.result;
      rv32ex_pkg::K_MUL:    res_sel = mul_out;
      rv32ex_pkg::K_DIV:    res_sel = last.qneg ? (~quo + 32'd1) : quo;
      rv32ex_pkg::K_REM:    res_sel = last.rneg ? (~rem + 32'd1) : rem;
      default:              res_sel = last.result;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {last.sdata, last.target, res_sel};
      out_user_r <= {last.ill, last.taken};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // An illegal code produces no other output.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("illegal transaction carries nonzero fields");

  // The target field is zero unless the branch is taken.
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[63:32] == '0)
    else $error("branch target set on untaken transaction");

  // A transaction leaving the sideband line always lands in the output register.
  a_line_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[N-1] |=> out_tvalid)
    else $error("transaction lost at output stage");

  // While stalled, the tail of the pipeline holds its valid bit.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> vld_r[N-1] == $past(vld_r[N-1]))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== sv/rv32ex_decode.sv =====
// First pipeline stage: decodes the operation, computes the K_SIMPLE results and
// prepares the multiplier and divider operands. Depends on rv32ex_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rv32ex_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [5:0]          operation,
  input  wire logic [31:0]         rs1_value,
  input  wire logic [31:0]         rs2_value,
  input  wire logic [31:0]         imm_value,
  input  wire logic [31:0]         pc_value,
  output logic                     vld_r,
  output rv32ex_pkg::side_t        side_r,
  output logic [31:0]              div_a_r,
  output logic [31:0]              div_b_r,
  output logic signed [32:0]       mul_a_r,
  output logic signed [32:0]       mul_b_r,
  output logic                     mul_hi_r
);

  rv32ex_pkg::side_t side_nxt;
  logic [31:0]        div_a_nxt, div_b_nxt;
  logic signed [32:0] mul_a_nxt, mul_b_nxt;
  logic               mul_hi_nxt;
  logic [31:0]        a, b, imm, pc, brtgt;
  logic               cond, sgn_div, sa, sb;

  always_comb begin
    a     = rs1_value;
    b     = rs2_value;
    imm   = imm_value;
    pc    = pc_value;
    brtgt = pc + imm;
    cond  = 1'b0;
    sgn_div = 1'b0;
    side_nxt        = '0;
    side_nxt.kind   = rv32ex_pkg::K_SIMPLE;
    mul_a_nxt  = {1'b0, a};
    mul_b_nxt  = {1'b0, b};
    mul_hi_nxt = 1'b1;
    case (operation)
      rv32ex_pkg::OP_ADDI, rv32ex_pkg::OP_LW: side_nxt.result = a + imm;
      rv32ex_pkg::OP_SLTI:  side_nxt.result = {31'd0, $signed(a) < $signed(imm)};
      rv32ex_pkg::OP_SLTIU: side_nxt.result = {31'd0, a < imm};
      rv32ex_pkg::OP_XORI:  side_nxt.result = a ^ imm;
      rv32ex_pkg::OP_ORI:   side_nxt.result = a | imm;
      rv32ex_pkg::OP_ANDI:  side_nxt.result = a & imm;
      rv32ex_pkg::OP_SLLI:  side_nxt.result = a << imm[rv32ex_pkg::SHAMT_W-1:0];
      rv32ex_pkg::OP_SRLI:  side_nxt.result = a >> imm[rv32ex_pkg::SHAMT_W-1:0];
      rv32ex_pkg::OP_SRAI:
        side_nxt.result = 32'($signed(a) >>> imm[rv32ex_pkg::SHAMT_W-1:0]);
      rv32ex_pkg::OP_FENCE, rv32ex_pkg::OP_FENCEI: side_nxt.result = '0;
      rv32ex_pkg::OP_ADD:   side_nxt.result = a + b;
      rv32ex_pkg::OP_SUB:   side_nxt.result = a - b;
      rv32ex_pkg::OP_SLL:   side_nxt.result = a << b[rv32ex_pkg::SHAMT_W-1:0];
      rv32ex_pkg::OP_SLT:   side_nxt.result = {31'd0, $signed(a) < $signed(b)};
      rv32ex_pkg::OP_SLTU:  side_nxt.result = {31'd0, a < b};
      rv32ex_pkg::OP_XOR:   side_nxt.result = a ^ b;
      rv32ex_pkg::OP_SRL:   side_nxt.result = a >> b[rv32ex_pkg::SHAMT_W-1:0];
      rv32ex_pkg::OP_SRA:
        side_nxt.result = 32'($signed(a) >>> b[rv32ex_pkg::SHAMT_W-1:0]);
      rv32ex_pkg::OP_OR:    side_nxt.result = a | b;
      rv32ex_pkg::OP_AND:   side_nxt.result = a & b;
      rv32ex_pkg::OP_MUL: begin
        side_nxt.kind = rv32ex_pkg::K_MUL;
        mul_hi_nxt    = 1'b0;
      end
      rv32ex_pkg::OP_MULH: begin
        side_nxt.kind = rv32ex_pkg::K_MUL;
        mul_a_nxt     = {a[31], a};
        mul_b_nxt     = {b[31], b};
      end
      rv32ex_pkg::OP_MULHSU: begin
        side_nxt.kind = rv32ex_pkg::K_MUL;
        mul_a_nxt     = {a[31], a};
      end
      rv32ex_pkg::OP_MULHU: side_nxt.kind = rv32ex_pkg::K_MUL;
      rv32ex_pkg::OP_DIV: begin
        side_nxt.kind = rv32ex_pkg::K_DIV;
        sgn_div       = 1'b1;
      end
      rv32ex_pkg::OP_DIVU: side_nxt.kind = rv32ex_pkg::K_DIV;
      rv32ex_pkg::OP_REM: begin
        side_nxt.kind = rv32ex_pkg::K_REM;
        sgn_div       = 1'b1;
      end
      rv32ex_pkg::OP_REMU: side_nxt.kind = rv32ex_pkg::K_REM;
      rv32ex_pkg::OP_JAL: begin
        side_nxt.result = pc + rv32ex_pkg::LINK_OFFSET;
        cond            = 1'b1;
      end
      rv32ex_pkg::OP_BEQ:  cond = (a == b);
      rv32ex_pkg::OP_BNE:  cond = (a != b);
      rv32ex_pkg::OP_BLT:  cond = $signed(a) < $signed(b);
      rv32ex_pkg::OP_BGE:  cond = !($signed(a) < $signed(b));
      rv32ex_pkg::OP_BLTU: cond = a < b;
      rv32ex_pkg::OP_BGEU: cond = a >= b;
      rv32ex_pkg::OP_SW: begin
        side_nxt.result = a + imm;
        side_nxt.sdata  = b;
      end
      default: side_nxt.ill = 1'b1;
    endcase
    side_nxt.taken  = cond;
    side_nxt.target = cond ? brtgt : '0;

    // The divider works on magnitudes; signs are restored after the last step.
    // A zero divisor leaves the all-ones quotient unsigned and the remainder
    // equal to the dividend.
    sa = sgn_div & a[31];
    sb = sgn_div & b[31];
    div_a_nxt = sa ? (~a + 32'd1) : a;
    div_b_nxt = sb ? (~b + 32'd1) : b;
    side_nxt.qneg = (sa ^ sb) & (b != '0);
    side_nxt.rneg = sa;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= side_nxt;
      div_a_r  <= div_a_nxt;
      div_b_r  <= div_b_nxt;
      mul_a_r  <= mul_a_nxt;
      mul_b_r  <= mul_b_nxt;
      mul_hi_r <= mul_hi_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rv32ex_mul.sv =====
// Multiplier: one registered 33x33 signed product, then a delay line that
// aligns the selected half with the divider output. Depends on rv32ex_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rv32ex_mul (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [32:0]  mul_a,
  input  wire logic signed [32:0]  mul_b,
  input  wire logic                mul_hi,
  output logic [31:0]              mul_out
);

  localparam int unsigned LINE = rv32ex_pkg::DIV_STEPS - 1;

  logic signed [65:0] prod_r;
  logic               hi_r;
  logic [31:0]        line_r [LINE];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mul_a * mul_b;
      hi_r   <= mul_hi;
      line_r[0] <= hi_r ? prod_r[63:32] : prod_r[31:0];
      for (int k = 1; k < LINE; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign mul_out = line_r[LINE-1];

endmodule
`default_nettype wire

// ===== sv/rv32ex_div.sv =====
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rv32ex_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rv32ex_div (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [31:0]  dividend,
  input  wire logic [31:0]  divisor,
  output logic [31:0]       quotient,
  output logic [31:0]       remainder
);

  localparam int unsigned N = rv32ex_pkg::DIV_STEPS;

  logic [31:0] rem_r [N];
  logic [31:0] quo_r [N];
  logic [31:0] dvs_r [N];
  logic [31:0] rem_nxt [N];
  logic [31:0] quo_nxt [N];
  logic [32:0] trial [N];
  logic [32:0] diff [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        trial[k] = {32'd0, dividend[31]};
        diff[k]  = trial[k] - {1'b0, divisor};
        rem_nxt[k] = diff[k][32] ? trial[k][31:0] : diff[k][31:0];
        quo_nxt[k] = {dividend[30:0], ~diff[k][32]};
      end else begin
        trial[k] = {rem_r[k-1], quo_r[k-1][31]};
        diff[k]  = trial[k] - {1'b0, dvs_r[k-1]};
        rem_nxt[k] = diff[k][32] ? trial[k][31:0] : diff[k][31:0];
        quo_nxt[k] = {quo_r[k-1][30:0], ~diff[k][32]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        dvs_r[k] <= (k == 0) ? divisor : dvs_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign quotient  = quo_r[N-1];
  assign remainder = rem_r[N-1];

endmodule
`default_nettype wire
